// ===== rtl/core/dfcb_pkg.sv =====
`default_nettype none

package dfcb_pkg;

  // Screen geometry
  localparam int SCREEN_WIDTH  = 320;
  localparam int SCREEN_HEIGHT = 200;
  localparam int SCREEN_PIXELS = SCREEN_WIDTH * SCREEN_HEIGHT;

  // Width that holds the pixel count and any 16-bit offset
  localparam int SCR_BITS = ($clog2(SCREEN_PIXELS + 1) > 16) ?
                            $clog2(SCREEN_PIXELS + 1) : 17;

  // Chunk header size in bytes
  localparam int HEADER_BYTES = 6;

  // Result kinds
  localparam logic [1:0] KIND_PIXEL = 2'd0;
  localparam logic [1:0] KIND_FILL  = 2'd1;
  localparam logic [1:0] KIND_DONE  = 2'd2;
  localparam logic [1:0] KIND_ERROR = 2'd3;

  // Error codes
  localparam logic [2:0] ERR_TRUNC_FILL   = 3'd0;
  localparam logic [2:0] ERR_NO_TERM      = 3'd1;
  localparam logic [2:0] ERR_TRUNC_CHUNK  = 3'd2;
  localparam logic [2:0] ERR_CHUNK_LONG   = 3'd3;
  localparam logic [2:0] ERR_OFF_SCREEN   = 3'd4;

  typedef struct packed {
    logic        frame_start;
    logic [15:0] frame_bytes;
    logic        lead_fill;
    logic [7:0]  data_byte;
  } req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] pixel_address;
    logic [7:0]  pixel_value;
    logic [2:0]  error_code;
    logic        last;
  } rsp_t;

  // Results of one committed request, in order
  typedef struct packed {
    logic [1:0] count;
    rsp_t       first;
    rsp_t       second;
  } push_t;

endpackage

`default_nettype wire

// ===== rtl/core/dfcb_in_reg.sv =====
`default_nettype none

module dfcb_in_reg
  import dfcb_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_stall,
  input  wire req_t req,
  input  wire logic commit,
  output logic      held_valid,
  output req_t      held
);

  // Stall only while a held request waits for the parser
  assign req_stall = held_valid && !commit;

  // Hold the request until the parser commits it
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!held_valid || commit) begin
      held_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!held_valid || commit) begin
      held <= req;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/dfcb_parser.sv =====
`default_nettype none

module dfcb_parser
  import dfcb_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic held_valid,
  input  wire req_t held,
  input  wire logic room,
  output logic      commit,
  output push_t     push
);

  localparam logic [3:0] PH_IDLE = 4'd0;
  localparam logic [3:0] PH_OPT0 = 4'd1;
  localparam logic [3:0] PH_OPT1 = 4'd2;
  localparam logic [3:0] PH_OFF0 = 4'd3;
  localparam logic [3:0] PH_OFF1 = 4'd4;
  localparam logic [3:0] PH_LEN0 = 4'd5;
  localparam logic [3:0] PH_LEN1 = 4'd6;
  localparam logic [3:0] PH_PIX  = 4'd7;

  localparam logic [SCR_BITS-1:0] SCREEN_C = SCR_BITS'(SCREEN_PIXELS);

  logic [3:0]  phase, phase_next;
  logic [15:0] bytes_left, bytes_left_next;
  logic [7:0]  option_lo, option_lo_next;
  logic [15:0] chunk_offset, chunk_offset_next;
  logic [7:0]  length_lo, length_lo_next;
  logic [15:0] write_address, write_address_next;
  logic [15:0] pixels_left, pixels_left_next;

  logic [15:0]         bl_dec;
  logic [15:0]         chunk_length;
  logic [SCR_BITS-1:0] offset_ext;
  logic [SCR_BITS-1:0] length_ext;
  logic [SCR_BITS-1:0] room_on_screen;
  rsp_t                res_a, res_b;
  logic [1:0]          n_res;

  assign commit = held_valid && room;

  assign bl_dec         = bytes_left - 16'd1;
  assign chunk_length   = {held.data_byte, length_lo};
  assign offset_ext     = SCR_BITS'(chunk_offset);
  assign length_ext     = SCR_BITS'(chunk_length);
  assign room_on_screen = SCREEN_C - offset_ext;

  // Advance the header parser by one byte
  always_comb begin
    phase_next         = phase;
    bytes_left_next    = bytes_left;
    option_lo_next     = option_lo;
    chunk_offset_next  = chunk_offset;
    length_lo_next     = length_lo;
    write_address_next = write_address;
    pixels_left_next   = pixels_left;
    res_a              = '0;
    res_b              = '0;
    n_res              = 2'd0;

    if (held.frame_start) begin
      bytes_left_next = held.frame_bytes;
      if (held.lead_fill) begin
        if (held.frame_bytes == 16'd0) begin
          res_a.kind       = KIND_ERROR;
          res_a.error_code = ERR_TRUNC_FILL;
          n_res            = 2'd1;
          phase_next       = PH_IDLE;
        end else begin
          res_a.kind        = KIND_FILL;
          res_a.pixel_value = held.data_byte;
          n_res             = 2'd1;
          bytes_left_next   = held.frame_bytes - 16'd1;
          if (held.frame_bytes - 16'd1 < 16'd2) begin
            res_b.kind       = KIND_ERROR;
            res_b.error_code = ERR_NO_TERM;
            n_res            = 2'd2;
            phase_next       = PH_IDLE;
          end else begin
            phase_next = PH_OPT0;
          end
        end
      end else if (held.frame_bytes < 16'd2) begin
        res_a.kind       = KIND_ERROR;
        res_a.error_code = ERR_NO_TERM;
        n_res            = 2'd1;
        phase_next       = PH_IDLE;
      end else begin
        // First byte is the low option byte
        option_lo_next  = held.data_byte;
        bytes_left_next = held.frame_bytes - 16'd1;
        phase_next      = PH_OPT1;
      end
    end else if (phase != PH_IDLE && bytes_left != 16'd0) begin
      bytes_left_next = bl_dec;
      unique case (phase)
        PH_OPT0: begin
          option_lo_next = held.data_byte;
          phase_next     = PH_OPT1;
        end
        PH_OPT1: begin
          if (option_lo == 8'd0 && held.data_byte == 8'd0) begin
            res_a.kind = KIND_DONE;
            n_res      = 2'd1;
            phase_next = PH_IDLE;
          end else if (bl_dec < 16'(HEADER_BYTES - 2)) begin
            res_a.kind       = KIND_ERROR;
            res_a.error_code = ERR_TRUNC_CHUNK;
            n_res            = 2'd1;
            phase_next       = PH_IDLE;
          end else begin
            phase_next = PH_OFF0;
          end
        end
        PH_OFF0: begin
          chunk_offset_next[7:0] = held.data_byte;
          phase_next             = PH_OFF1;
        end
        PH_OFF1: begin
          chunk_offset_next[15:8] = held.data_byte;
          phase_next              = PH_LEN0;
        end
        PH_LEN0: begin
          length_lo_next = held.data_byte;
          phase_next     = PH_LEN1;
        end
        PH_LEN1: begin
          if (chunk_length > bl_dec) begin
            res_a.kind       = KIND_ERROR;
            res_a.error_code = ERR_CHUNK_LONG;
            n_res            = 2'd1;
            phase_next       = PH_IDLE;
          end else if (offset_ext > SCREEN_C || length_ext > room_on_screen) begin
            res_a.kind       = KIND_ERROR;
            res_a.error_code = ERR_OFF_SCREEN;
            n_res            = 2'd1;
            phase_next       = PH_IDLE;
          end else if (chunk_length == 16'd0) begin
            if (bl_dec < 16'd2) begin
              res_a.kind       = KIND_ERROR;
              res_a.error_code = ERR_NO_TERM;
              n_res            = 2'd1;
              phase_next       = PH_IDLE;
            end else begin
              phase_next = PH_OPT0;
            end
          end else begin
            write_address_next = chunk_offset;
            pixels_left_next   = chunk_length;
            phase_next         = PH_PIX;
          end
        end
        PH_PIX: begin
          res_a.kind          = KIND_PIXEL;
          res_a.pixel_address = write_address;
          res_a.pixel_value   = held.data_byte;
          n_res               = 2'd1;
          write_address_next  = write_address + 16'd1;
          pixels_left_next    = pixels_left - 16'd1;
          if (pixels_left == 16'd1) begin
            if (bl_dec < 16'd2) begin
              res_b.kind       = KIND_ERROR;
              res_b.error_code = ERR_NO_TERM;
              n_res            = 2'd2;
              phase_next       = PH_IDLE;
            end else begin
              phase_next = PH_OPT0;
            end
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end

    res_a.last = (n_res == 2'd1);
    res_b.last = 1'b1;
  end

  // Hand the results of a committed request to the queue
  always_comb begin
    push.count  = commit ? n_res : 2'd0;
    push.first  = res_a;
    push.second = res_b;
  end

  // Update parser state on commit
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      bytes_left <= 16'd0;
    end else if (commit) begin
      phase      <= phase_next;
      bytes_left <= bytes_left_next;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      option_lo     <= option_lo_next;
      chunk_offset  <= chunk_offset_next;
      length_lo     <= length_lo_next;
      write_address <= write_address_next;
      pixels_left   <= pixels_left_next;
    end
  end

`ifndef SYNTH
  // A done or error result leaves the parser idle
  a_end_goes_idle: assert property (@(posedge clk) disable iff (rst)
    (push.count != 2'd0 &&
     ((push.count == 2'd1 && (push.first.kind == KIND_DONE ||
                              push.first.kind == KIND_ERROR)) ||
      push.count == 2'd2)) |=> phase == PH_IDLE)
    else $error("parser not idle after frame end");

  // A second result is always an error
  a_second_is_error: assert property (@(posedge clk) disable iff (rst)
    push.count == 2'd2 |-> push.second.kind == KIND_ERROR)
    else $error("second result is not an error");

  // Pixel phase always has pixels pending
  a_pix_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PIX |-> pixels_left != 16'd0)
    else $error("pixel phase with no pixels left");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/dfcb_out_fifo.sv =====
`default_nettype none

module dfcb_out_fifo
  import dfcb_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire push_t push,
  output logic       room,
  output logic       rsp_valid,
  input  wire logic  rsp_stall,
  output rsp_t       rsp
);

  rsp_t       slots [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;
  logic       pop;

  // Two free entries are enough for any request
  assign room      = (count <= 3'd2);
  assign rsp_valid = (count != 3'd0);
  assign rsp       = slots[rd_ptr];
  assign pop       = rsp_valid && !rsp_stall;

  // Write the results of one request in order
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      slots[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      slots[wr_ptr + 2'd1] <= push.second;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      count  <= 3'd0;
    end else begin
      wr_ptr <= wr_ptr + push.count;
      if (pop) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      count <= count + 3'(push.count) - 3'(pop);
    end
  end

`ifndef SYNTH
  // Never overfill the queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push.count != 2'd0 |-> count <= 3'd2)
    else $error("result queue overflow");

  // Occupancy follows pushes and pops
  a_count_track: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> count == $past(count) + 3'($past(push.count)) - 3'($past(pop)))
    else $error("result queue count mismatch");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/delta_frame_chunk_blitter_top.sv =====
`default_nettype none

// Delta-frame chunk blitter. Each request carries one byte of a delta-coded
// frame; a start request also latches the frame length and whether the
// first byte is a whole-screen fill color. Chunk headers (option, offset,
// length, little-endian) are parsed byte by byte and every pixel byte
// becomes one pixel-write response at offset+i; the frame ends with a done
// response or one error response, after which bytes are ignored until the
// next start. One request is taken per clock cycle while the queue has room.
// A request gives at most two responses (a pixel or fill, then an error), and
// the response side drains one per cycle while rsp_stall is low, so sustained
// throughput is one request per cycle as long as requests average at most one
// response; the four-entry response queue sets the limit, stalling requests
// while it holds more than two responses. An accepted request is registered,
// then parsed, and its responses are written to the queue and offered from it.
module delta_frame_chunk_blitter_top
  import dfcb_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_stall,
  input  wire req_t req,
  output logic      rsp_valid,
  input  wire logic rsp_stall,
  output rsp_t      rsp
);

  logic  held_valid;
  req_t  held;
  logic  commit;
  logic  room;
  push_t push;

  dfcb_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .commit     (commit),
    .held_valid (held_valid),
    .held       (held)
  );

  dfcb_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .held_valid (held_valid),
    .held       (held),
    .room       (room),
    .commit     (commit),
    .push       (push)
  );

  dfcb_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire
